// ===== sv/pfsd_pkg.sv =====
// Shared types, constants and helpers of the packet flood and scan detector.
// Used by packet_flood_scan_detector_core and tb_top; depends on nothing else.
package pfsd_pkg;

    localparam int unsigned DEF_SOURCES     = 64;
    localparam int unsigned DEF_PORT_SLOTS  = 16;
    localparam int unsigned DEF_LOCAL_ADDRS = 4;
    localparam int unsigned LOCAL_REGS      = 4;
    localparam int          SZW             = 7;

    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [15:0] PORT_SSH      = 16'd22;
    localparam logic [15:0] PORT_TELNET   = 16'd23;
    localparam logic [15:0] PORT_RDP      = 16'd3389;
    localparam logic [31:0] WINDOW_SEC    = 32'd60;
    localparam logic [31:0] SCAN_IDLE_SEC = 32'd359;
    localparam logic [15:0] GUARD_LIMIT   = 16'd10;
    localparam logic [SZW-1:0] SCAN_LIMIT = SZW'(10);
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] SYN_LIMIT_RST  = 16'd100;
    localparam logic [15:0] UDP_LIMIT_RST  = 16'd150;
    localparam logic [15:0] ICMP_LIMIT_RST = 16'd50;

    typedef enum logic [1:0] {
        CLS_TCP   = 2'd0,
        CLS_UDP   = 2'd1,
        CLS_ICMP  = 2'd2,
        CLS_OTHER = 2'd3
    } t_cls;

    typedef enum logic [1:0] {
        SVC_NONE   = 2'd0,
        SVC_SSH    = 2'd1,
        SVC_TELNET = 2'd2,
        SVC_RDP    = 2'd3
    } t_svc;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_SYN   = 3'd1,
        KIND_SCAN  = 3'd2,
        KIND_BRUTE = 3'd3,
        KIND_UDP   = 3'd4,
        KIND_ICMP  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        REG_ADDR0       = 3'd0,
        REG_ADDR1       = 3'd1,
        REG_ADDR2       = 3'd2,
        REG_ADDR3       = 3'd3,
        REG_ENABLE      = 3'd4,
        REG_SYN_LIMIT   = 3'd5,
        REG_UDP_LIMIT   = 3'd6,
        REG_ICMP_LIMIT  = 3'd7
    } t_reg;

    typedef struct packed {
        logic                 rate_seen;
        logic                 guard_seen;
        logic                 scan_seen;
        logic [15:0]          rate_count;
        logic [31:0]          rate_start;
        logic [31:0]          guard_start;
        logic [2:0][15:0]     guard_count;
        logic [31:0]          scan_last;
        logic [SZW-1:0]       scan_size;
    } t_rec;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
    endfunction

endpackage

// ===== sv/packet_flood_scan_detector_core.sv =====
// Top level of the packet flood and scan detector.
// Holds the source table, per-source record memory and scan port memory.
// Depends on pfsd_pkg.
//
// Usage: one parsed packet header is a request on the input channel
// (i_in_valid, o_in_stall); at most one result leaves on the output channel
// (o_out_valid, i_out_stall). Non-IPv4 packets are counted and give no result.
// Registers are written through i_cfg_valid/i_cfg_index/i_cfg_data, always ready.
// The block works on one request at a time and holds o_in_stall high meanwhile.
// A request that reaches no detector goes straight to the final state. Otherwise the
// source table is searched one entry per cycle through the address memory, the
// record is read and checked, SYN requests search the stored scan ports one per
// cycle, and the final state writes the record back.
// Sources are allocated in order and never freed, so a fill count marks the
// valid table entries and no clearing pass follows reset.
// Reset clears the table, the packet counter and the registers to defaults.
// A stalled result stays in the output register; the next finished result
// waits until it is taken.
module packet_flood_scan_detector_core #(
    parameter int unsigned SOURCES     = pfsd_pkg::DEF_SOURCES,
    parameter int unsigned PORT_SLOTS  = pfsd_pkg::DEF_PORT_SLOTS,
    parameter int unsigned LOCAL_ADDRS = pfsd_pkg::DEF_LOCAL_ADDRS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_tcp_flags,
    input  logic [31:0] i_now_sec,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_threat,
    output logic [2:0]  o_threat_kind,
    output logic [1:0]  o_service,
    output logic [1:0]  o_packet_class,
    output logic        o_untracked,
    output logic [31:0] o_packets_seen,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pfsd_pkg::*;

    localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CW = $clog2(SOURCES + 1);
    localparam int AW = $clog2(SOURCES * PORT_SLOTS);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_RREC   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state;

    logic [31:0] r_local [LOCAL_REGS];
    logic [3:0]  r_enable;
    logic [15:0] r_syn_limit, r_udp_limit, r_icmp_limit;

    logic [31:0]    r_total;
    logic [CW-1:0]  r_fill, r_idx;
    logic           r_cmp_v;
    logic [SW-1:0]  r_cmp_idx, r_slot;
    logic           r_new, r_track, r_untracked;
    logic [31:0]    r_src, r_now;
    logic [15:0]    r_port;
    logic           r_syn, r_ack;
    t_cls           r_cls;
    t_svc           r_svc;
    t_rec           r_rec;
    logic           r_rate_fire, r_guard_fire, r_scan_fire;
    logic [SZW-1:0] r_j, r_n;
    logic           r_pcmp_v;
    logic [AW-1:0]  r_base;

    logic           r_out_valid, r_o_threat, r_o_untracked;
    logic [2:0]     r_o_kind;
    logic [1:0]     r_o_service, r_o_class;
    logic [31:0]    r_o_total;

    logic [31:0] ent_mem [SOURCES];
    t_rec        rec_mem [SOURCES];
    logic [15:0] port_mem [SOURCES * PORT_SLOTS];
    logic [31:0] r_ent_rd;
    t_rec        r_rec_rd;
    logic [15:0] r_port_rd;

    logic        c_accept, c_ipv4, c_incoming, c_needs, c_syn;
    t_cls        c_cls;
    t_svc        c_svc;
    logic        c_match, c_notfound, c_ent_we;
    t_rec        c_old, c_rec;
    logic [31:0] c_el_rate, c_el_guard, c_el_scan;
    logic        c_rate_do, c_guard_do, c_scan_do, c_rate_fire, c_guard_fire;
    logic [15:0] c_limit;
    logic [SZW-1:0] c_size0;
    logic        c_pmatch, c_pend, c_pwe;
    logic [SZW-1:0] c_n_new;
    logic        c_load;
    t_kind       c_kind;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign c_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        c_ipv4     = (i_ether_type == ETH_IPV4);
        c_syn      = i_tcp_flags[1];
        c_incoming = 1'b0;
        for (int i = 0; i < int'(LOCAL_ADDRS) && i < int'(LOCAL_REGS); i++) begin
            if (r_enable[i] && r_local[i] == i_dst_addr) begin
                c_incoming = 1'b1;
            end
        end
        if (i_ip_proto == PROTO_TCP) begin
            c_cls = CLS_TCP;
        end else if (i_ip_proto == PROTO_UDP) begin
            c_cls = CLS_UDP;
        end else if (i_ip_proto == PROTO_ICMP) begin
            c_cls = CLS_ICMP;
        end else begin
            c_cls = CLS_OTHER;
        end
        if (i_dst_port == PORT_SSH) begin
            c_svc = SVC_SSH;
        end else if (i_dst_port == PORT_TELNET) begin
            c_svc = SVC_TELNET;
        end else if (i_dst_port == PORT_RDP) begin
            c_svc = SVC_RDP;
        end else begin
            c_svc = SVC_NONE;
        end
        c_needs = c_incoming && ((c_cls == CLS_UDP) || (c_cls == CLS_ICMP) ||
                  ((c_cls == CLS_TCP) && (c_syn || c_svc != SVC_NONE)));
    end

    assign c_match    = r_cmp_v && (r_ent_rd == r_src);
    assign c_notfound = !r_cmp_v && (r_idx >= r_fill);
    assign c_ent_we   = (r_state == ST_SEARCH) && !c_match && c_notfound &&
                        (r_fill < CW'(SOURCES));

    always_comb begin
        c_old      = r_new ? t_rec'('0) : r_rec_rd;
        c_rec      = c_old;
        c_el_rate  = r_now - c_old.rate_start;
        c_el_guard = r_now - c_old.guard_start;
        c_el_scan  = r_now - c_old.scan_last;
        c_rate_do  = ((r_cls == CLS_TCP) && r_syn && !r_ack) ||
                     (r_cls == CLS_UDP) || (r_cls == CLS_ICMP);
        c_guard_do = (r_cls == CLS_TCP) && (r_svc != SVC_NONE);
        c_scan_do  = (r_cls == CLS_TCP) && r_syn;
        c_rate_fire  = 1'b0;
        c_guard_fire = 1'b0;
        case (r_cls)
            CLS_UDP:  c_limit = r_udp_limit;
            CLS_ICMP: c_limit = r_icmp_limit;
            default:  c_limit = r_syn_limit;
        endcase
        if (c_rate_do) begin
            if (!c_old.rate_seen || c_el_rate > WINDOW_SEC) begin
                c_rec.rate_seen  = 1'b1;
                c_rec.rate_count = 16'd1;
                c_rec.rate_start = r_now;
            end else begin
                c_rec.rate_count = sat_inc(c_old.rate_count);
                c_rate_fire      = (c_rec.rate_count > c_limit);
            end
        end
        if (c_guard_do) begin
            if (!c_old.guard_seen || c_el_guard > WINDOW_SEC) begin
                c_rec.guard_seen  = 1'b1;
                c_rec.guard_start = r_now;
                for (int k = 0; k < 3; k++) begin
                    c_rec.guard_count[k] = (r_svc == t_svc'(k + 1)) ? 16'd1 : 16'd0;
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (r_svc == t_svc'(k + 1)) begin
                        c_rec.guard_count[k] = sat_inc(c_old.guard_count[k]);
                        if (c_rec.guard_count[k] > GUARD_LIMIT) begin
                            c_guard_fire = 1'b1;
                        end
                    end
                end
            end
        end
        c_size0 = (!c_old.scan_seen || c_el_scan > SCAN_IDLE_SEC) ? '0 : c_old.scan_size;
    end

    assign c_pmatch = r_pcmp_v && (r_port_rd == r_port);
    assign c_pend   = c_pmatch || (!r_pcmp_v && r_j >= r_n);
    assign c_pwe    = (r_state == ST_SCAN) && c_pend && !c_pmatch &&
                      (r_n < SZW'(PORT_SLOTS));
    assign c_n_new  = c_pwe ? r_n + SZW'(1) : r_n;
    assign c_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_guard_fire) begin
            c_kind = KIND_BRUTE;
        end else if (r_scan_fire) begin
            c_kind = KIND_SCAN;
        end else if (r_rate_fire) begin
            case (r_cls)
                CLS_UDP:  c_kind = KIND_UDP;
                CLS_ICMP: c_kind = KIND_ICMP;
                default:  c_kind = KIND_SYN;
            endcase
        end else begin
            c_kind = KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ent_we) begin
            ent_mem[r_fill[SW-1:0]] <= r_src;
        end
        r_ent_rd <= ent_mem[r_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && r_track) begin
            rec_mem[r_slot] <= r_rec;
        end
        r_rec_rd <= rec_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (c_pwe) begin
            port_mem[r_base + AW'(r_n)] <= r_port;
        end
        r_port_rd <= port_mem[r_base + AW'(r_j)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(LOCAL_REGS); i++) begin
                r_local[i] <= '0;
            end
            r_enable     <= '0;
            r_syn_limit  <= SYN_LIMIT_RST;
            r_udp_limit  <= UDP_LIMIT_RST;
            r_icmp_limit <= ICMP_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg'(i_cfg_index))
                REG_ADDR0:      r_local[0]   <= i_cfg_data;
                REG_ADDR1:      r_local[1]   <= i_cfg_data;
                REG_ADDR2:      r_local[2]   <= i_cfg_data;
                REG_ADDR3:      r_local[3]   <= i_cfg_data;
                REG_ENABLE:     r_enable     <= i_cfg_data[3:0];
                REG_SYN_LIMIT:  r_syn_limit  <= i_cfg_data[15:0];
                REG_UDP_LIMIT:  r_udp_limit  <= i_cfg_data[15:0];
                REG_ICMP_LIMIT: r_icmp_limit <= i_cfg_data[15:0];
                default:        r_enable     <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_pcmp_v    <= 1'b0;
        end else begin
            if (c_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (c_accept) begin
                        r_total      <= r_total + 32'd1;
                        r_src        <= i_src_addr;
                        r_now        <= i_now_sec;
                        r_port       <= i_dst_port;
                        r_syn        <= c_syn;
                        r_ack        <= i_tcp_flags[4];
                        r_cls        <= c_cls;
                        r_svc        <= c_svc;
                        r_track      <= 1'b0;
                        r_untracked  <= 1'b0;
                        r_rate_fire  <= 1'b0;
                        r_guard_fire <= 1'b0;
                        r_scan_fire  <= 1'b0;
                        r_idx        <= '0;
                        r_cmp_v      <= 1'b0;
                        if (c_ipv4) begin
                            r_state <= c_needs ? ST_SEARCH : ST_DONE;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (r_idx < r_fill) begin
                        r_idx     <= r_idx + CW'(1);
                        r_cmp_idx <= r_idx[SW-1:0];
                        r_cmp_v   <= 1'b1;
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                    if (c_match) begin
                        r_slot  <= r_cmp_idx;
                        r_new   <= 1'b0;
                        r_state <= ST_RREC;
                    end else if (c_notfound) begin
                        if (c_ent_we) begin
                            r_slot  <= r_fill[SW-1:0];
                            r_fill  <= r_fill + CW'(1);
                            r_new   <= 1'b1;
                            r_state <= ST_RREC;
                        end else begin
                            r_untracked <= 1'b1;
                            r_state     <= ST_DONE;
                        end
                    end
                end
                ST_RREC: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_rec        <= c_rec;
                    r_track      <= 1'b1;
                    r_rate_fire  <= c_rate_fire;
                    r_guard_fire <= c_guard_fire;
                    r_n          <= c_size0;
                    r_j          <= '0;
                    r_pcmp_v     <= 1'b0;
                    r_base       <= AW'(r_slot * PORT_SLOTS);
                    r_state      <= c_scan_do ? ST_SCAN : ST_DONE;
                end
                ST_SCAN: begin
                    if (r_j < r_n) begin
                        r_j      <= r_j + SZW'(1);
                        r_pcmp_v <= 1'b1;
                    end else begin
                        r_pcmp_v <= 1'b0;
                    end
                    if (c_pend) begin
                        r_scan_fire         <= (c_n_new > SCAN_LIMIT);
                        r_rec.scan_size     <= (c_n_new > SCAN_LIMIT) ? '0 : c_n_new;
                        r_rec.scan_last     <= r_now;
                        r_rec.scan_seen     <= 1'b1;
                        r_state             <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (c_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_o_threat    <= r_untracked || r_rate_fire || r_scan_fire || r_guard_fire;
            r_o_kind      <= c_kind;
            r_o_service   <= r_guard_fire ? r_svc : SVC_NONE;
            r_o_class     <= r_cls;
            r_o_untracked <= r_untracked;
            r_o_total     <= r_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_threat       = r_o_threat;
    assign o_threat_kind  = r_o_kind;
    assign o_service      = r_o_service;
    assign o_packet_class = r_o_class;
    assign o_untracked    = r_o_untracked;
    assign o_packets_seen = r_o_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(SOURCES))
        else $error("source fill count beyond table size");

    a_cmp_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && r_cmp_v) |-> (CW'(r_cmp_idx) < r_fill))
        else $error("compared an unallocated source entry");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the final state");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_n <= SZW'(PORT_SLOTS)))
        else $error("scan set size beyond slot count");

endmodule

// ===== verif/tb_top.sv =====
// Testbench of packet_flood_scan_detector_core: drives parsed packet headers and register
// writes, predicts every result with its own detector model and checks each result field.
// Depends on pfsd_pkg and packet_flood_scan_detector_core.
`timescale 1ns / 1ps

module tb_top;
    import pfsd_pkg::*;

    typedef struct {
        logic [15:0] ether;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] port;
        logic [7:0]  flags;
        logic [31:0] now;
    } t_pkt_hdr;

    typedef struct {
        logic        threat;
        logic [2:0]  kind;
        logic [1:0]  service;
        logic [1:0]  cls;
        logic        untracked;
        logic [31:0] seen;
    } t_verdict;

    class flood_scoreboard;
        logic [31:0] local_addr [4];
        logic [3:0]  addr_enable;
        logic [15:0] syn_limit, udp_limit, icmp_limit;
        bit          src_valid [64];
        logic [31:0] src_addr [64];
        bit          rate_seen [64];
        logic [15:0] rate_count [64];
        logic [31:0] rate_start [64];
        bit          guard_seen [64];
        logic [15:0] guard_count [64][3];
        logic [31:0] guard_start [64];
        bit          scan_seen [64];
        logic [31:0] scan_last [64];
        int          scan_size [64];
        logic [15:0] scan_ports [64][16];
        logic [31:0] total;
        t_verdict    verdicts [$];
        int          errors;

        function new();
            foreach (local_addr[i]) local_addr[i] = '0;
            addr_enable = '0;
            syn_limit = SYN_LIMIT_RST;
            udp_limit = UDP_LIMIT_RST;
            icmp_limit = ICMP_LIMIT_RST;
            foreach (src_valid[i]) src_valid[i] = 0;
            total = '0;
            errors = 0;
        endfunction

        function void set_reg(t_reg r, logic [31:0] d);
            case (r)
                REG_ADDR0, REG_ADDR1, REG_ADDR2, REG_ADDR3: local_addr[int'(r)] = d;
                REG_ENABLE: addr_enable = d[3:0];
                REG_SYN_LIMIT: syn_limit = d[15:0];
                REG_UDP_LIMIT: udp_limit = d[15:0];
                default: icmp_limit = d[15:0];
            endcase
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function int lookup(logic [31:0] a);
            int free_slot;
            free_slot = -1;
            for (int i = 0; i < 64; i++) begin
                if (src_valid[i]) begin
                    if (src_addr[i] == a) return i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                src_valid[free_slot] = 1;
                src_addr[free_slot] = a;
                rate_seen[free_slot] = 0;
                guard_seen[free_slot] = 0;
                scan_seen[free_slot] = 0;
                scan_size[free_slot] = 0;
            end
            return free_slot;
        endfunction

        function bit rate_hit(int s, logic [31:0] now, logic [15:0] limit);
            logic [31:0] el;
            el = now - rate_start[s];
            if (!rate_seen[s] || el > 32'd60) begin
                rate_seen[s] = 1;
                rate_count[s] = 16'd1;
                rate_start[s] = now;
                return 0;
            end
            rate_count[s] = bump(rate_count[s]);
            return rate_count[s] > limit;
        endfunction

        function bit guard_hit(int s, logic [31:0] now, int svc);
            logic [31:0] el;
            el = now - guard_start[s];
            if (!guard_seen[s] || el > 32'd60) begin
                for (int k = 0; k < 3; k++) guard_count[s][k] = '0;
                guard_count[s][svc] = 16'd1;
                guard_seen[s] = 1;
                guard_start[s] = now;
                return 0;
            end
            guard_count[s][svc] = bump(guard_count[s][svc]);
            return guard_count[s][svc] > 16'd10;
        endfunction

        function bit scan_hit(int s, logic [31:0] now, logic [15:0] port);
            logic [31:0] el;
            int n;
            bit found;
            el = now - scan_last[s];
            found = 0;
            if (!scan_seen[s] || (el / 32'd60) > 32'd5) scan_size[s] = 0;
            n = scan_size[s];
            for (int i = 0; i < n; i++)
                if (scan_ports[s][i] == port) found = 1;
            if (!found && n < 16) begin
                scan_ports[s][n] = port;
                n++;
            end
            scan_size[s] = n;
            scan_last[s] = now;
            scan_seen[s] = 1;
            if (n > 10) begin
                scan_size[s] = 0;
                return 1;
            end
            return 0;
        endfunction

        function void note_packet(t_pkt_hdr p);
            t_verdict v;
            bit incoming, needs, syn, ack;
            int svc, s;
            total++;
            if (p.ether != ETH_IPV4) return;
            incoming = 0;
            for (int i = 0; i < 4; i++)
                if (addr_enable[i] && local_addr[i] == p.dst) incoming = 1;
            v = '{default: '0};
            if (p.proto == PROTO_TCP) v.cls = CLS_TCP;
            else if (p.proto == PROTO_UDP) v.cls = CLS_UDP;
            else if (p.proto == PROTO_ICMP) v.cls = CLS_ICMP;
            else v.cls = CLS_OTHER;
            if (p.port == PORT_SSH) svc = 0;
            else if (p.port == PORT_TELNET) svc = 1;
            else if (p.port == PORT_RDP) svc = 2;
            else svc = -1;
            syn = p.flags[1];
            ack = p.flags[4];
            needs = incoming && (v.cls == CLS_UDP || v.cls == CLS_ICMP ||
                                 (v.cls == CLS_TCP && (syn || svc >= 0)));
            if (needs) begin
                s = lookup(p.src);
                if (s < 0) begin
                    v.untracked = 1;
                    v.threat = 1;
                end else if (v.cls == CLS_TCP) begin
                    if (syn && !ack && rate_hit(s, p.now, syn_limit)) begin
                        v.threat = 1; v.kind = KIND_SYN;
                    end
                    if (syn && scan_hit(s, p.now, p.port)) begin
                        v.threat = 1; v.kind = KIND_SCAN;
                    end
                    if (svc >= 0 && guard_hit(s, p.now, svc)) begin
                        v.threat = 1; v.kind = KIND_BRUTE; v.service = 2'(svc + 1);
                    end
                end else if (v.cls == CLS_UDP) begin
                    if (rate_hit(s, p.now, udp_limit)) begin
                        v.threat = 1; v.kind = KIND_UDP;
                    end
                end else begin
                    if (rate_hit(s, p.now, icmp_limit)) begin
                        v.threat = 1; v.kind = KIND_ICMP;
                    end
                end
            end
            v.seen = total;
            verdicts.insert(verdicts.size(), v);
        endfunction

        function void check_result(t_verdict g);
            t_verdict e;
            if (verdicts.size() == 0) begin
                $error("result with no request waiting");
                errors++;
                return;
            end
            e = verdicts.pop_front();
            if (g.threat !== e.threat) begin
                $error("threat expected %0d got %0d", e.threat, g.threat); errors++;
            end
            if (g.kind !== e.kind) begin
                $error("threat_kind expected %0d got %0d", e.kind, g.kind); errors++;
            end
            if (g.service !== e.service) begin
                $error("service expected %0d got %0d", e.service, g.service); errors++;
            end
            if (g.cls !== e.cls) begin
                $error("packet_class expected %0d got %0d", e.cls, g.cls); errors++;
            end
            if (g.untracked !== e.untracked) begin
                $error("untracked expected %0d got %0d", e.untracked, g.untracked); errors++;
            end
            if (g.seen !== e.seen) begin
                $error("packets_seen expected %0d got %0d", e.seen, g.seen); errors++;
            end
        endfunction
    endclass

    localparam int DRAIN = 100;
    localparam int LIMIT = 3000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [15:0] i_ether_type = '0;
    logic [7:0]  i_ip_proto = '0;
    logic [31:0] i_src_addr = '0;
    logic [31:0] i_dst_addr = '0;
    logic [15:0] i_dst_port = '0;
    logic [7:0]  i_tcp_flags = '0;
    logic [31:0] i_now_sec = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic        o_threat;
    logic [2:0]  o_threat_kind;
    logic [1:0]  o_service;
    logic [1:0]  o_packet_class;
    logic        o_untracked;
    logic [31:0] o_packets_seen;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    flood_scoreboard sb = new();
    int          cycles = 0;
    bit          quiet = 0;
    int          hold_len = 0;
    int          stall_left = 0;
    logic [31:0] clock_sec = '0;
    logic [31:0] locals [4];
    logic [31:0] sources [8];
    int          fill_pct = 0;

    packet_flood_scan_detector_core uut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_threat, o_threat_kind, o_service, o_packet_class,
                              o_untracked, o_packets_seen});

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                stall_left = hold_len;
                hold_len = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    task automatic send_packet(t_pkt_hdr p);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_ether_type <= p.ether;
        i_ip_proto <= p.proto;
        i_src_addr <= p.src;
        i_dst_addr <= p.dst;
        i_dst_port <= p.port;
        i_tcp_flags <= p.flags;
        i_now_sec <= p.now;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_packet(p);
    endtask

    task automatic settle();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [31:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= r;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.set_reg(r, d);
        if (r <= REG_ADDR3) locals[int'(r)] = d;
    endtask

    task automatic set_limits(logic [15:0] syn_l, logic [15:0] udp_l, logic [15:0] icmp_l);
        write_reg(REG_SYN_LIMIT, {16'h0, syn_l});
        write_reg(REG_UDP_LIMIT, {16'h0, udp_l});
        write_reg(REG_ICMP_LIMIT, {16'h0, icmp_l});
    endtask

    function automatic t_pkt_hdr mk(logic [15:0] e, logic [7:0] pr, logic [31:0] s,
                                    logic [31:0] d, logic [15:0] po, logic [7:0] f);
        t_pkt_hdr p;
        p = '{e, pr, s, d, po, f, clock_sec};
        return p;
    endfunction

    function automatic t_pkt_hdr random_packet();
        t_pkt_hdr p;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) clock_sec = clock_sec + $urandom_range(300, 420);
        else if (r < 10) clock_sec = clock_sec + $urandom_range(55, 70);
        else if (r < 40) clock_sec = clock_sec + $urandom_range(1, 3);
        if ($urandom_range(0, 9) == 0)
            return mk(16'($urandom), 8'($urandom), $urandom, $urandom,
                      16'($urandom), 8'($urandom));
        p = mk(ETH_IPV4, PROTO_TCP, sources[$urandom_range(0, 7)],
               locals[$urandom_range(0, 3)], 16'($urandom_range(1000, 1019)), 8'h02);
        if ($urandom_range(0, 99) < fill_pct) p.src = $urandom;
        if ($urandom_range(0, 19) == 0) p.ether = 16'($urandom);
        if ($urandom_range(0, 9) == 0) p.dst = $urandom;
        r = $urandom_range(0, 99);
        if (r < 20) p.proto = PROTO_UDP;
        else if (r < 35) p.proto = PROTO_ICMP;
        else if (r < 40) p.proto = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 12) p.port = PORT_SSH;
        else if (r < 20) p.port = PORT_TELNET;
        else if (r < 28) p.port = PORT_RDP;
        else if (r < 35) p.port = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) p.flags = 8'h12;
        else if (r < 30) p.flags = 8'($urandom);
        else if (r < 40) p.flags = 8'h10;
        return p;
    endfunction

    task automatic random_run(int n);
        repeat (n) send_packet(random_packet());
    endtask

    initial begin
        foreach (locals[i]) locals[i] = '0;
        foreach (sources[i]) sources[i] = $urandom;
        sources[0] = 32'h0;
        sources[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Default registers: no local address is enabled, so nothing is incoming.
        send_packet(mk(ETH_IPV4, PROTO_UDP, 32'h1, 32'h0, 16'd53, 8'h00));
        send_packet(mk(16'h86DD, PROTO_TCP, 32'h1, 32'h0, PORT_SSH, 8'h02));
        settle();

        write_reg(REG_ADDR0, 32'h0);
        write_reg(REG_ADDR1, 32'hFFFF_FFFF);
        write_reg(REG_ADDR2, $urandom);
        write_reg(REG_ADDR3, $urandom);
        write_reg(REG_ENABLE, 32'hF);
        set_limits(16'd0, 16'd0, 16'd0);

        // Directed part: field extremes, every class and every detector path.
        send_packet(mk(16'h0000, 8'hFF, 32'h0, 32'h0, 16'h0, 8'hFF));
        send_packet(mk(16'hFFFF, 8'h00, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 8'h00));
        send_packet(mk(ETH_IPV4, 8'h00, 32'h5, 32'h0, 16'h0, 8'h02));
        send_packet(mk(ETH_IPV4, 8'hFF, 32'h5, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'h1234, 16'd80, 8'h02));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'h0, 16'd80, 8'h10));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'h0, 16'd80, 8'h02));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'h0, 16'd81, 8'h02));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'h0, 16'd82, 8'h12));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'h0, 16'd82, 8'hFF));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'hFFFF_FFFF, PORT_SSH, 8'h10));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'hFFFF_FFFF, PORT_TELNET, 8'h00));
        send_packet(mk(ETH_IPV4, PROTO_TCP, 32'h5, 32'hFFFF_FFFF, PORT_RDP, 8'h02));
        send_packet(mk(ETH_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'd53, 8'h00));
        send_packet(mk(ETH_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'd53, 8'h00));
        send_packet(mk(ETH_IPV4, PROTO_ICMP, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h00));
        send_packet(mk(ETH_IPV4, PROTO_ICMP, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h00));
        clock_sec = 32'd61;
        send_packet(mk(ETH_IPV4, PROTO_ICMP, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h00));
        settle();

        // Small limits: floods, scans and brute force all fire often.
        write_reg(REG_ADDR2, $urandom);
        write_reg(REG_ADDR3, $urandom);
        set_limits(16'd3, 16'd4, 16'd2);
        hold_len = 3000;
        random_run(300);
        settle();

        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_ENABLE, 32'h5);
        random_run(300);
        settle();

        // Time runs across the 32-bit wrap.
        clock_sec = 32'hFFFF_FE00;
        write_reg(REG_ENABLE, 32'hA);
        set_limits(16'd20, 16'd30, 16'd10);
        random_run(300);
        settle();

        write_reg(REG_ENABLE, 32'hF);
        set_limits(16'd6, 16'd8, 16'd5);
        random_run(300);
        // New sources fill the table; later ones go untracked.
        fill_pct = 40;
        random_run(150);
        quiet = 1;
        random_run(150);
        settle();

        if (sb.errors == 0 && sb.verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
